/* rtl/bsf_pkg.sv */
// Shared types and constants of the bilinear sample fetch block.
package bsf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int SAMPLE_W  = 16;
    localparam int COORD_W   = 16;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    // Integer part of a coordinate plus headroom for the +1 neighbor.
    localparam int POS_W     = COORD_W + 1;

    localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic clr;    // clear the accumulator
        logic mul_x;  // product <= sample * x weight
        logic mul_y;  // product <= product * y weight
        logic add;    // accumulator += product
    } t_mac_ctl;

endpackage

/* rtl/bsf_req_if.sv */
// Request channel: sample writes and interpolation queries.
interface bsf_req_if;
    import bsf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [PIX_W-1:0]     pixel_row;
    logic [PIX_W-1:0]     pixel_col;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [COORD_W-1:0]   query_y;
    logic [COORD_W-1:0]   query_x;

    modport source (
        output valid, command, pixel_row, pixel_col, sample_value, query_y, query_x,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_row, pixel_col, sample_value, query_y, query_x,
        output ready
    );
endinterface

/* rtl/bsf_rsp_if.sv */
// Response channel: interpolated value and outside-frame flag.
interface bsf_rsp_if;
    import bsf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SAMPLE_W-1:0]  blended_value;
    logic                 outside_frame;

    modport source (
        output valid, blended_value, outside_frame,
        input  ready
    );
    modport sink (
        input  valid, blended_value, outside_frame,
        output ready
    );
endinterface

/* rtl/bsf_frame_mem.sv */
// Single-port frame memory with registered read data.
module bsf_frame_mem #(
    parameter int DEPTH = bsf_pkg::DEF_MAX_WIDTH * bsf_pkg::DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_addr,
    input  logic [bsf_pkg::SAMPLE_W-1:0]  i_wdata,
    output logic [bsf_pkg::SAMPLE_W-1:0]  o_rdata
);
    import bsf_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bsf_mac.sv */
// Shared multiplier with product register and blend accumulator.
module bsf_mac #(
    parameter int FRAC_BITS = bsf_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  bsf_pkg::t_mac_ctl             i_ctl,
    input  logic [bsf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [FRAC_BITS:0]            i_weight,
    output logic [bsf_pkg::SAMPLE_W-1:0]  o_result
);
    import bsf_pkg::*;

    localparam int OPA_W  = SAMPLE_W + FRAC_BITS;
    localparam int PROD_W = SAMPLE_W + 2 * FRAC_BITS;
    localparam int FULL_W = OPA_W + FRAC_BITS + 1;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_acc;
    logic [OPA_W-1:0]  opa;
    logic [FULL_W-1:0] full;

    // First pass takes the sample, second pass the partial product.
    assign opa  = i_ctl.mul_x ? OPA_W'(i_sample) : r_prod[OPA_W-1:0];
    assign full = FULL_W'(opa) * FULL_W'(i_weight);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_x || i_ctl.mul_y) begin
            r_prod <= full[PROD_W-1:0];
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Weights sum to 2^(2*FRAC_BITS): drop the fraction.
    assign o_result = r_acc[2*FRAC_BITS +: SAMPLE_W];

endmodule

/* rtl/bilinear_sample_fetch.sv */
// Bilinear sample fetch: a write request gives no response. A query takes 4 neighbors x 4
// steps (read, x multiply, y multiply, accumulate) through one shared multiplier and
// single-port frame memory, then a done step loads the response; with the base pixel outside
// the frame it goes straight to the done step. The next request is taken the cycle after the
// load, so a query completes before the next is taken. A waiting response stalls only the
// completion of the next query. Reset clears control state and sets width and height to 256.
module bilinear_sample_fetch #(
    parameter int MAX_WIDTH  = bsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bsf_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bsf_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsf_pkg::CFG_W-1:0]      i_cfg_data,
    bsf_req_if.sink                        i_req,
    bsf_rsp_if.source                      o_rsp
);
    import bsf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WT_W  = FRAC_BITS + 1;

    localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MX   = 3'd2;
    localparam logic [2:0] S_MY   = 3'd3;
    localparam logic [2:0] S_AC   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [1:0] NB_LAST = 2'd3;

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_nb, n_nb;
    logic [CFG_W-1:0]     r_width, r_height;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic                 r_right, r_down, r_outside;
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_value;
    logic                 r_out_flag;

    logic                 req_acc, is_query, out_load;
    logic [POS_W-1:0]     w_eff, h_eff, q_ypos, q_xpos;
    logic                 q_outside, q_right, q_down;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr, nb_addr, mem_addr;
    logic [ROW_W-1:0]     nb_row;
    logic [COL_W-1:0]     nb_col;
    logic [SAMPLE_W-1:0]  rdata, mac_sample, mac_result;
    logic [WT_W-1:0]      wx, wy, mac_weight;
    logic                 nb_valid;
    t_mac_ctl             mac_ctl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign is_query    = (i_req.command == CMD_QUERY);

    // Clamp the configured frame to the store size
    assign w_eff = (POS_W'(r_width) > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : POS_W'(r_width);
    assign h_eff = (POS_W'(r_height) > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT)
                                                            : POS_W'(r_height);

    assign q_ypos    = POS_W'(i_req.query_y) >> FRAC_BITS;
    assign q_xpos    = POS_W'(i_req.query_x) >> FRAC_BITS;
    assign q_outside = (q_xpos >= w_eff) || (q_ypos >= h_eff);
    assign q_right   = (q_xpos + POS_W'(1)) < w_eff;
    assign q_down    = (q_ypos + POS_W'(1)) < h_eff;

    assign wr_en   = req_acc && (i_req.command == CMD_WRITE)
                  && (32'(i_req.pixel_row) < 32'(MAX_HEIGHT))
                  && (32'(i_req.pixel_col) < 32'(MAX_WIDTH));
    assign wr_addr = AW'(AW'(i_req.pixel_row) * AW'(MAX_WIDTH)) + AW'(i_req.pixel_col);

    // Bit 0 of the neighbor count steps right, bit 1 steps down
    assign nb_row   = r_row + ROW_W'(r_nb[1]);
    assign nb_col   = r_col + COL_W'(r_nb[0]);
    assign nb_addr  = AW'(AW'(nb_row) * AW'(MAX_WIDTH)) + AW'(nb_col);
    assign mem_addr = (r_state == S_IDLE) ? wr_addr : nb_addr;
    assign nb_valid = (!r_nb[0] || r_right) && (!r_nb[1] || r_down);

    assign wx = r_nb[0] ? WT_W'(r_fx) : (ONE - WT_W'(r_fx));
    assign wy = r_nb[1] ? WT_W'(r_fy) : (ONE - WT_W'(r_fy));
    assign mac_weight = (r_state == S_MX) ? wx : wy;
    // Drop neighbors beyond the right or lower edge
    assign mac_sample = nb_valid ? rdata : '0;

    bsf_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_addr  (mem_addr),
        .i_wdata (i_req.sample_value),
        .o_rdata (rdata)
    );

    bsf_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_sample (mac_sample),
        .i_weight (mac_weight),
        .o_result (mac_result)
    );

    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        n_nb    = r_nb;
        mac_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (req_acc && is_query) begin
                    mac_ctl.clr = 1'b1;
                    n_state     = q_outside ? S_DONE : S_RD;
                end
            end
            S_RD: n_state = S_MX;
            S_MX: begin
                mac_ctl.mul_x = 1'b1;
                n_state       = S_MY;
            end
            S_MY: begin
                mac_ctl.mul_y = 1'b1;
                n_state       = S_AC;
            end
            S_AC: begin
                mac_ctl.add = 1'b1;
                n_nb        = r_nb + 2'd1;
                n_state     = (r_nb == NB_LAST) ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nb        <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nb    <= n_nb;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the query operands and response payload
    always_ff @(posedge i_clk) begin
        if (req_acc && is_query) begin
            r_row     <= q_ypos[ROW_W-1:0];
            r_col     <= q_xpos[COL_W-1:0];
            r_fy      <= i_req.query_y[FRAC_BITS-1:0];
            r_fx      <= i_req.query_x[FRAC_BITS-1:0];
            r_right   <= q_right;
            r_down    <= q_down;
            r_outside <= q_outside;
        end
        if (out_load) begin
            r_out_value <= r_outside ? '0 : mac_result;
            r_out_flag  <= r_outside;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.blended_value = r_out_value;
    assign o_rsp.outside_frame = r_out_flag;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.outside_frame) |-> (o_rsp.blended_value == '0))
        else $error("outside-frame response carries a nonzero value");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.command == CMD_QUERY) |=> !i_req.ready)
        else $error("request accepted while a query is in progress");

    a_nb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_nb == 2'd0))
        else $error("neighbor count not back at the base pixel when idle");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_state) == S_DONE))
        else $error("response raised outside the completion step");

endmodule
